// ===== rtl/fbpa_pkg.sv =====
// ---------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// field widths, request and status codes, register indexes, reset values
// ---------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int ADDR_W     = 15;
   localparam int STATUS_W   = 3;
   localparam int PAGES_W    = 4;
   localparam int CNT_W      = 9;
   localparam int TOTAL_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int OBJ_W      = 7;
   localparam int HDR_W      = 3;
   localparam int PAD_W      = 3;
   localparam int ALIGN_W    = 5;
   localparam int OPP_W      = 6;
   localparam int MAXP_W     = 4;

   // layout widths: raw block is at most 7+2*7+127, rounded up to a multiple of an alignment of at most 31
   localparam int STRIDE_W = 8;
   localparam int FIRST_W  = 6;
   localparam int USER_W   = 4;

   // parameter defaults
   localparam int DEF_PAGE_SLOTS          = 8;
   localparam int DEF_MAX_BLOCKS_PER_PAGE = 32;
   localparam int DEF_PAGE_SPAN_BYTES     = 4096;
   localparam int DEF_POINTER_BYTES       = 8;

   // register reset values
   localparam logic [OBJ_W-1:0]   RST_OBJECT_SIZE      = OBJ_W'(16);
   localparam logic [HDR_W-1:0]   RST_HEADER_BYTES     = HDR_W'(0);
   localparam logic [PAD_W-1:0]   RST_PAD_BYTES        = PAD_W'(0);
   localparam logic [ALIGN_W-1:0] RST_ALIGNMENT        = ALIGN_W'(0);
   localparam logic [OPP_W-1:0]   RST_OBJECTS_PER_PAGE = OPP_W'(4);
   localparam logic [MAXP_W-1:0]  RST_MAX_PAGES        = MAXP_W'(0);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_SIZE      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_BYTES        = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGNMENT        = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECTS_PER_PAGE = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAGES        = CSR_IDX_W'(5);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_START   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK            = 3'd0,
      STS_NO_MEMORY     = 3'd1,
      STS_NO_PAGES      = 3'd2,
      STS_BAD_ADDRESS   = 3'd3,
      STS_BAD_BOUNDARY  = 3'd4,
      STS_MULTIPLE_FREE = 3'd5
   } status_type;

   typedef struct packed {
      logic [STRIDE_W-1:0] stride;
      logic [FIRST_W-1:0]  first;
      logic [USER_W-1:0]   user;
   } layout_type;

endpackage

`default_nettype wire

// ===== rtl/fbpa_link_ram.sv =====
// ---------------------------------------------------------------------------
// fbpa_link_ram: free list link memory
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module fbpa_link_ram #(
   parameter int ADDR_BITS = 8,
   parameter int DATA_BITS = 9
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [1<<ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/fbpa_layout.sv =====
// ---------------------------------------------------------------------------
// fbpa_layout: block layout calculator
// rounds stride and first offset up by repeated adds when an alignment is set, then counts fitting blocks
// ---------------------------------------------------------------------------
`default_nettype none

module fbpa_layout #(
   parameter int MAX_BLOCKS_PER_PAGE = 32,
   parameter int PAGE_SPAN_BYTES     = 4096,
   parameter int POINTER_BYTES       = 8,
   parameter int CW                  = 6
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [fbpa_pkg::OBJ_W-1:0]     object_size,
   input  wire logic [fbpa_pkg::HDR_W-1:0]     header_bytes,
   input  wire logic [fbpa_pkg::PAD_W-1:0]     pad_bytes,
   input  wire logic [fbpa_pkg::ALIGN_W-1:0]   alignment,
   input  wire logic [fbpa_pkg::OPP_W-1:0]     objects_per_page,
   output fbpa_pkg::layout_type                layout,
   output logic      [CW-1:0]                  count,
   output logic                                done
);

   import fbpa_pkg::*;

   localparam int EW   = $clog2(PAGE_SPAN_BYTES + 512);
   localparam int LIMW = (CW > OPP_W) ? CW : OPP_W;
   localparam int RST_STRIDE = int'(RST_HEADER_BYTES) + 2 * int'(RST_PAD_BYTES)
                             + int'(RST_OBJECT_SIZE);
   localparam int RST_LIM = (int'(RST_OBJECTS_PER_PAGE) < MAX_BLOCKS_PER_PAGE)
                          ? int'(RST_OBJECTS_PER_PAGE) : MAX_BLOCKS_PER_PAGE;
   localparam int RST_FIT = (PAGE_SPAN_BYTES - POINTER_BYTES) / RST_STRIDE;
   localparam int RST_COUNT = (RST_LIM < RST_FIT) ? RST_LIM : RST_FIT;

   typedef enum logic [1:0] {
      L_IDLE,
      L_STRIDE,
      L_FIRST,
      L_COUNT
   } lay_state_type;

   lay_state_type        state_ff;
   layout_type           layout_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        n_ff;
   logic [EW-1:0]        acc_ff;
   logic                 done_ff;
   logic [STRIDE_W-1:0]  raw;
   logic [EW-1:0]        sum_in;
   logic [LIMW-1:0]      lim;

   always_comb begin
      raw = STRIDE_W'(header_bytes) + STRIDE_W'({pad_bytes, 1'b0}) + STRIDE_W'(object_size);
      if (raw == '0) begin
         raw = STRIDE_W'(1);
      end
   end

   // one adder, shared by rounding and block counting
   assign sum_in = acc_ff + ((state_ff == L_COUNT) ? EW'(layout_ff.stride) : EW'(alignment));

   assign lim = (LIMW'(objects_per_page) > LIMW'(MAX_BLOCKS_PER_PAGE))
              ? LIMW'(MAX_BLOCKS_PER_PAGE) : LIMW'(objects_per_page);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= L_IDLE;
         layout_ff.stride <= STRIDE_W'(RST_STRIDE);
         layout_ff.first  <= FIRST_W'(POINTER_BYTES);
         layout_ff.user   <= USER_W'(int'(RST_HEADER_BYTES) + int'(RST_PAD_BYTES));
         count_ff         <= CW'(RST_COUNT);
         n_ff             <= '0;
         acc_ff           <= '0;
         done_ff          <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (start) begin
                  layout_ff.user <= USER_W'(header_bytes) + USER_W'(pad_bytes);
                  n_ff           <= '0;
                  if (alignment == '0) begin
                     layout_ff.stride <= raw;
                     layout_ff.first  <= FIRST_W'(POINTER_BYTES);
                     acc_ff           <= EW'(POINTER_BYTES);
                     state_ff         <= L_COUNT;
                  end else begin
                     acc_ff   <= '0;
                     state_ff <= L_STRIDE;
                  end
               end
            end
            L_STRIDE: begin
               if (acc_ff >= EW'(raw)) begin
                  layout_ff.stride <= STRIDE_W'(acc_ff);
                  acc_ff           <= '0;
                  state_ff         <= L_FIRST;
               end else begin
                  acc_ff <= sum_in;
               end
            end
            L_FIRST: begin
               if (acc_ff >= EW'(POINTER_BYTES)) begin
                  layout_ff.first <= FIRST_W'(acc_ff);
                  state_ff        <= L_COUNT;
               end else begin
                  acc_ff <= sum_in;
               end
            end
            L_COUNT: begin
               if ((LIMW'(n_ff) < lim) && (sum_in <= EW'(PAGE_SPAN_BYTES))) begin
                  acc_ff <= sum_in;
                  n_ff   <= n_ff + CW'(1);
               end else begin
                  count_ff <= n_ff;
                  done_ff  <= 1'b1;
                  state_ff <= L_IDLE;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign layout = layout_ff;
   assign count  = count_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

// ===== rtl/fixed_block_pool_allocator.sv =====
// ---------------------------------------------------------------------------
// fixed_block_pool_allocator: paged pool of same-size blocks
// LIFO free list of block links in a memory, under a multi-cycle sequencer
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    action, address
//   rsp_      out         rsp_valid/rsp_ready    status, user_address, counters
//   csr_      in          csr_valid/csr_ready    index, data (register write)
//
// one request at a time; req_ready is high only while the sequencer is idle
// allocate from a non-empty list pops the head through the link memory; a free
//   also walks the slots and then the blocks of one page before its push
// page creation pushes one block per cycle; start adds the layout
//   calculation first, on the layout unit's shared adder
// release scans one slot per cycle, then walks the free list, reading and
//   then checking each entry through the link memory read port
// reset is synchronous; no clearing pass; the response register holds the
//   result while rsp_ready is low, and no new request is taken until it goes
`default_nettype none

module fixed_block_pool_allocator #(
   parameter int PAGE_SLOTS          = fbpa_pkg::DEF_PAGE_SLOTS,
   parameter int MAX_BLOCKS_PER_PAGE = fbpa_pkg::DEF_MAX_BLOCKS_PER_PAGE,
   parameter int PAGE_SPAN_BYTES     = fbpa_pkg::DEF_PAGE_SPAN_BYTES,
   parameter int POINTER_BYTES       = fbpa_pkg::DEF_POINTER_BYTES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [fbpa_pkg::ACTION_W-1:0]     req_action,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]       req_address,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [fbpa_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [fbpa_pkg::ADDR_W-1:0]       rsp_user_address,
   output logic      [fbpa_pkg::PAGES_W-1:0]      rsp_pages_released,
   output logic      [fbpa_pkg::CNT_W-1:0]        rsp_objects_in_use,
   output logic      [fbpa_pkg::CNT_W-1:0]        rsp_free_objects,
   output logic      [fbpa_pkg::PAGES_W-1:0]      rsp_pages_in_use,
   output logic      [fbpa_pkg::CNT_W-1:0]        rsp_most_objects,
   output logic      [fbpa_pkg::TOTAL_W-1:0]      rsp_allocation_count,
   output logic      [fbpa_pkg::TOTAL_W-1:0]      rsp_free_count,
   // register write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]   csr_data
);

   import fbpa_pkg::*;

   // block reference = {slot, index in page}; list entries carry a null flag on top
   localparam int SW  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
   localparam int IW  = (MAX_BLOCKS_PER_PAGE > 1) ? $clog2(MAX_BLOCKS_PER_PAGE) : 1;
   localparam int BW  = SW + IW;
   localparam int LW  = BW + 1;
   localparam int NB  = 1 << BW;
   localparam int PER = 1 << IW;
   localparam int CW  = $clog2(MAX_BLOCKS_PER_PAGE + 1);
   localparam int EW  = $clog2(PAGE_SPAN_BYTES + 512);
   localparam int AW0 = $clog2((PAGE_SLOTS + 1) * PAGE_SPAN_BYTES) + 1;
   localparam int AW  = (AW0 > ADDR_W) ? AW0 : ADDR_W + 1;
   localparam int PW  = IW + STRIDE_W;
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LAYOUT,
      S_NEWPAGE,
      S_PUSH,
      S_POP_RD,
      S_POP_DONE,
      S_FREE_SLOT,
      S_FREE_SCAN,
      S_FREE_PUSH,
      S_REL_SCAN,
      S_WALK_RD,
      S_WALK_CHK,
      S_RESP
   } state_type;

   // configuration registers
   logic [OBJ_W-1:0]   object_size_ff;
   logic [HDR_W-1:0]   header_bytes_ff;
   logic [PAD_W-1:0]   pad_bytes_ff;
   logic [ALIGN_W-1:0] alignment_ff;
   logic [OPP_W-1:0]   objects_per_page_ff;
   logic [MAXP_W-1:0]  max_pages_ff;

   // sequencer state
   state_type          state_ff;
   action_type         act_ff;
   logic [LW-1:0]      head_ff;
   logic [LW-1:0]      cur_ff;
   logic [LW-1:0]      prev_ff;
   logic [SW-1:0]      slot_ff;
   logic [CW-1:0]      idx_ff;
   logic [AW-1:0]      base_ff;
   logic [ADDR_W-1:0]  blk_ff;
   logic [EW-1:0]      off_ff;
   logic [EW-1:0]      pos_ff;
   logic [PW-1:0]      prod_ff;
   logic [PAGE_SLOTS-1:0] slot_used_ff;
   logic [PAGE_SLOTS-1:0] rel_mask_ff;
   logic [NB-1:0]      free_bits_ff;

   // counters and response payload
   logic [CNT_W-1:0]   in_use_ff;
   logic [CNT_W-1:0]   free_cnt_ff;
   logic [PAGES_W-1:0] pages_ff;
   logic [CNT_W-1:0]   peak_ff;
   logic [TOTAL_W-1:0] alloc_total_ff;
   logic [TOTAL_W-1:0] free_total_ff;
   logic [PAGES_W-1:0] rel_n_ff;
   status_type         status_ff;
   logic [ADDR_W-1:0]  uaddr_ff;

   // layout unit
   layout_type         lay;
   logic [CW-1:0]      lay_count;
   logic               lay_done;
   logic               lay_start;

   // link memory
   logic               mem_we;
   logic [BW-1:0]      mem_waddr;
   logic [LW-1:0]      mem_wdata;
   logic               mem_re;
   logic [BW-1:0]      mem_raddr;
   logic [LW-1:0]      mem_rdata;

   // helpers
   logic               req_fire;
   logic               slot_found;
   logic [SW-1:0]      slot_free;
   logic [BW-1:0]      blk_ref;
   logic [CNT_W:0]     free_add_in;
   logic [CNT_W-1:0]   in_use_inc_in;
   logic [PER-1:0]     cmask;
   logic [PER-1:0]     slot_bits;
   logic               slot_all_free;
   logic [AW-1:0]      blk_ext;
   logic [AW-1:0]      uaddr_in;
   logic               cur_released;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign lay_start = req_fire && (action_type'(req_action) == ACT_START);

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         object_size_ff      <= RST_OBJECT_SIZE;
         header_bytes_ff     <= RST_HEADER_BYTES;
         pad_bytes_ff        <= RST_PAD_BYTES;
         alignment_ff        <= RST_ALIGNMENT;
         objects_per_page_ff <= RST_OBJECTS_PER_PAGE;
         max_pages_ff        <= RST_MAX_PAGES;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OBJECT_SIZE:      object_size_ff      <= OBJ_W'(csr_data);
            CSR_HEADER_BYTES:     header_bytes_ff     <= HDR_W'(csr_data);
            CSR_PAD_BYTES:        pad_bytes_ff        <= PAD_W'(csr_data);
            CSR_ALIGNMENT:        alignment_ff        <= ALIGN_W'(csr_data);
            CSR_OBJECTS_PER_PAGE: objects_per_page_ff <= OPP_W'(csr_data);
            CSR_MAX_PAGES:        max_pages_ff        <= MAXP_W'(csr_data);
            default: ;
         endcase
      end
   end

   fbpa_layout #(
      .MAX_BLOCKS_PER_PAGE (MAX_BLOCKS_PER_PAGE),
      .PAGE_SPAN_BYTES     (PAGE_SPAN_BYTES),
      .POINTER_BYTES       (POINTER_BYTES),
      .CW                  (CW)
   ) u_layout (
      .clock            (clock),
      .reset            (reset),
      .start            (lay_start),
      .object_size      (object_size_ff),
      .header_bytes     (header_bytes_ff),
      .pad_bytes        (pad_bytes_ff),
      .alignment        (alignment_ff),
      .objects_per_page (objects_per_page_ff),
      .layout           (lay),
      .count            (lay_count),
      .done             (lay_done)
   );

   fbpa_link_ram #(
      .ADDR_BITS (BW),
      .DATA_BITS (LW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // lowest unused slot for a new page
   always_comb begin
      slot_found = 1'b0;
      slot_free  = '0;
      for (int s = PAGE_SLOTS - 1; s >= 0; s--) begin
         if (!slot_used_ff[s]) begin
            slot_found = 1'b1;
            slot_free  = SW'(s);
         end
      end
   end

   // valid block positions of one page, and the free bits of the scanned slot
   always_comb begin
      for (int j = 0; j < PER; j++) begin
         cmask[j] = (CW'(j) < lay_count) && (j < MAX_BLOCKS_PER_PAGE);
      end
   end

   assign slot_bits     = free_bits_ff[slot_ff * PER +: PER];
   assign slot_all_free = ((slot_bits & cmask) == cmask);

   assign blk_ref       = {slot_ff, idx_ff[IW-1:0]};
   assign blk_ext       = AW'(blk_ff);
   assign free_add_in   = (CNT_W+1)'(free_cnt_ff) + (CNT_W+1)'(lay_count);
   assign in_use_inc_in = (in_use_ff == CNT_MAX) ? in_use_ff : in_use_ff + CNT_W'(1);
   assign uaddr_in      = AW'(head_ff[BW-1:IW]) * AW'(PAGE_SPAN_BYTES) + AW'(lay.first)
                        + AW'(prod_ff) + AW'(lay.user);
   assign cur_released  = rel_mask_ff[cur_ff[BW-1:IW]];

   // link memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = blk_ref;
      mem_wdata = head_ff;
      mem_re    = 1'b0;
      mem_raddr = head_ff[BW-1:0];
      unique case (state_ff)
         S_PUSH, S_FREE_PUSH: begin
            mem_we = 1'b1;
         end
         S_POP_RD: begin
            mem_re = 1'b1;
         end
         S_WALK_RD: begin
            mem_re    = !cur_ff[BW];
            mem_raddr = cur_ff[BW-1:0];
         end
         S_WALK_CHK: begin
            // unlink behind a kept entry
            mem_we    = cur_released && !prev_ff[BW];
            mem_waddr = prev_ff[BW-1:0];
            mem_wdata = mem_rdata;
         end
         default: ;
      endcase
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         act_ff         <= ACT_ALLOC;
         head_ff        <= {1'b1, {BW{1'b0}}};
         slot_used_ff   <= '0;
         free_bits_ff   <= '0;
         rel_mask_ff    <= '0;
         in_use_ff      <= '0;
         free_cnt_ff    <= '0;
         pages_ff       <= '0;
         peak_ff        <= '0;
         alloc_total_ff <= '0;
         free_total_ff  <= '0;
         rel_n_ff       <= '0;
         status_ff      <= STS_OK;
         uaddr_ff       <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  act_ff    <= action_type'(req_action);
                  status_ff <= STS_OK;
                  uaddr_ff  <= '0;
                  rel_n_ff  <= '0;
                  unique case (action_type'(req_action))
                     ACT_ALLOC: begin
                        if (!head_ff[BW]) begin
                           state_ff <= S_POP_RD;
                        end else if ((max_pages_ff != '0) && (pages_ff >= max_pages_ff)) begin
                           status_ff <= STS_NO_PAGES;
                           state_ff  <= S_RESP;
                        end else begin
                           state_ff <= S_NEWPAGE;
                        end
                     end
                     ACT_FREE: begin
                        // null pointer answers ok and does nothing
                        if (req_address == '0) begin
                           state_ff <= S_RESP;
                        end else if (req_address < ADDR_W'(lay.user)) begin
                           status_ff <= STS_BAD_ADDRESS;
                           state_ff  <= S_RESP;
                        end else begin
                           blk_ff   <= req_address - ADDR_W'(lay.user);
                           slot_ff  <= '0;
                           base_ff  <= '0;
                           state_ff <= S_FREE_SLOT;
                        end
                     end
                     ACT_RELEASE: begin
                        slot_ff     <= '0;
                        rel_mask_ff <= '0;
                        state_ff    <= S_REL_SCAN;
                     end
                     ACT_START: begin
                        head_ff        <= {1'b1, {BW{1'b0}}};
                        slot_used_ff   <= '0;
                        free_bits_ff   <= '0;
                        in_use_ff      <= '0;
                        free_cnt_ff    <= '0;
                        pages_ff       <= '0;
                        peak_ff        <= '0;
                        alloc_total_ff <= '0;
                        free_total_ff  <= '0;
                        state_ff       <= S_LAYOUT;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end

            S_LAYOUT: begin
               if (lay_done) begin
                  state_ff <= S_NEWPAGE;
               end
            end

            S_NEWPAGE: begin
               if (slot_found && (lay_count != '0)) begin
                  slot_used_ff[slot_free] <= 1'b1;
                  slot_ff                 <= slot_free;
                  idx_ff                  <= '0;
                  state_ff                <= S_PUSH;
               end else begin
                  status_ff <= STS_NO_MEMORY;
                  state_ff  <= S_RESP;
               end
            end

            // push the page's blocks in ascending order
            S_PUSH: begin
               head_ff               <= {1'b0, blk_ref};
               free_bits_ff[blk_ref] <= 1'b1;
               idx_ff                <= idx_ff + CW'(1);
               if (idx_ff + CW'(1) == lay_count) begin
                  pages_ff    <= pages_ff + PAGES_W'(1);
                  free_cnt_ff <= (free_add_in > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX
                                                                     : CNT_W'(free_add_in);
                  state_ff    <= (act_ff == ACT_ALLOC) ? S_POP_RD : S_RESP;
               end
            end

            S_POP_RD: begin
               prod_ff  <= PW'(head_ff[IW-1:0]) * PW'(lay.stride);
               state_ff <= S_POP_DONE;
            end

            S_POP_DONE: begin
               head_ff                        <= mem_rdata;
               free_bits_ff[head_ff[BW-1:0]]  <= 1'b0;
               uaddr_ff                       <= ADDR_W'(uaddr_in);
               if (alloc_total_ff != TOTAL_MAX) begin
                  alloc_total_ff <= alloc_total_ff + TOTAL_W'(1);
               end
               in_use_ff <= in_use_inc_in;
               if (free_cnt_ff != '0) begin
                  free_cnt_ff <= free_cnt_ff - CNT_W'(1);
               end
               if (in_use_inc_in > peak_ff) begin
                  peak_ff <= in_use_inc_in;
               end
               state_ff <= S_RESP;
            end

            // find the slot that holds the block start
            S_FREE_SLOT: begin
               if (blk_ext < base_ff + AW'(PAGE_SPAN_BYTES)) begin
                  if (!slot_used_ff[slot_ff]) begin
                     status_ff <= STS_BAD_ADDRESS;
                     state_ff  <= S_RESP;
                  end else if (EW'(blk_ext - base_ff) < EW'(lay.first)) begin
                     status_ff <= STS_BAD_ADDRESS;
                     state_ff  <= S_RESP;
                  end else begin
                     off_ff   <= EW'(blk_ext - base_ff);
                     pos_ff   <= EW'(lay.first);
                     idx_ff   <= '0;
                     state_ff <= S_FREE_SCAN;
                  end
               end else if (slot_ff == SW'(PAGE_SLOTS - 1)) begin
                  status_ff <= STS_BAD_ADDRESS;
                  state_ff  <= S_RESP;
               end else begin
                  slot_ff <= slot_ff + SW'(1);
                  base_ff <= base_ff + AW'(PAGE_SPAN_BYTES);
               end
            end

            // step through block starts of the page
            S_FREE_SCAN: begin
               if (idx_ff == lay_count) begin
                  status_ff <= STS_BAD_ADDRESS;
                  state_ff  <= S_RESP;
               end else if (off_ff == pos_ff) begin
                  if (free_bits_ff[blk_ref]) begin
                     status_ff <= STS_MULTIPLE_FREE;
                     state_ff  <= S_RESP;
                  end else begin
                     state_ff <= S_FREE_PUSH;
                  end
               end else if (off_ff < pos_ff + EW'(lay.stride)) begin
                  status_ff <= STS_BAD_BOUNDARY;
                  state_ff  <= S_RESP;
               end else begin
                  pos_ff <= pos_ff + EW'(lay.stride);
                  idx_ff <= idx_ff + CW'(1);
               end
            end

            S_FREE_PUSH: begin
               head_ff               <= {1'b0, blk_ref};
               free_bits_ff[blk_ref] <= 1'b1;
               if (free_total_ff != TOTAL_MAX) begin
                  free_total_ff <= free_total_ff + TOTAL_W'(1);
               end
               if (in_use_ff != '0) begin
                  in_use_ff <= in_use_ff - CNT_W'(1);
               end
               if (free_cnt_ff != CNT_MAX) begin
                  free_cnt_ff <= free_cnt_ff + CNT_W'(1);
               end
               state_ff <= S_RESP;
            end

            // mark fully free pages, one slot a cycle
            S_REL_SCAN: begin
               if (slot_used_ff[slot_ff] && slot_all_free) begin
                  rel_mask_ff[slot_ff]  <= 1'b1;
                  slot_used_ff[slot_ff] <= 1'b0;
                  rel_n_ff              <= rel_n_ff + PAGES_W'(1);
                  if (pages_ff != '0) begin
                     pages_ff <= pages_ff - PAGES_W'(1);
                  end
                  free_cnt_ff <= (free_cnt_ff > CNT_W'(lay_count))
                               ? free_cnt_ff - CNT_W'(lay_count) : '0;
               end
               if (slot_ff == SW'(PAGE_SLOTS - 1)) begin
                  cur_ff   <= head_ff;
                  prev_ff  <= {1'b1, {BW{1'b0}}};
                  state_ff <= S_WALK_RD;
               end else begin
                  slot_ff <= slot_ff + SW'(1);
               end
            end

            S_WALK_RD: begin
               if (cur_ff[BW] || (rel_mask_ff == '0)) begin
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_WALK_CHK;
               end
            end

            // drop entries of released pages from the list
            S_WALK_CHK: begin
               if (cur_released) begin
                  free_bits_ff[cur_ff[BW-1:0]] <= 1'b0;
                  if (prev_ff[BW]) begin
                     head_ff <= mem_rdata;
                  end
               end else begin
                  prev_ff <= cur_ff;
               end
               cur_ff   <= mem_rdata;
               state_ff <= S_WALK_RD;
            end

            S_RESP: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid            = (state_ff == S_RESP);
   assign rsp_status           = status_ff;
   assign rsp_user_address     = uaddr_ff;
   assign rsp_pages_released   = rel_n_ff;
   assign rsp_objects_in_use   = in_use_ff;
   assign rsp_free_objects     = free_cnt_ff;
   assign rsp_pages_in_use     = pages_ff;
   assign rsp_most_objects     = peak_ff;
   assign rsp_allocation_count = alloc_total_ff;
   assign rsp_free_count       = free_total_ff;

   // an empty list means no free blocks are counted
   a_empty_list_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && head_ff[BW]) |-> (free_cnt_ff == '0))
      else $error("free count nonzero with empty free list");

   // page count follows the slot map
   a_pages_match_slots: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (pages_ff == PAGES_W'($countones(slot_used_ff))))
      else $error("page count differs from used slots");

   // never ready for a request while a response is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   // a taken response returns to idle
   a_resp_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("sequencer not idle after response");

endmodule

`default_nettype wire
